@@ rtl/core/skf_pkg.sv @@
// skf_pkg: shared types, codes and helpers of the scalar Kalman filter core.
// No dependencies.
`default_nettype none

package skf_pkg;

  // Operation codes carried by the op field of a command word
  typedef enum logic [1:0] {
    OP_PREDICT  = 2'd0,
    OP_UPDATE   = 2'd1,
    OP_PRED_UPD = 2'd2,
    OP_RESTART  = 2'd3
  } op_t;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_INIT_POS  = 2'd0;
  localparam logic [1:0] REG_INIT_VAR  = 2'd1;
  localparam logic [1:0] REG_PROC_NSE  = 2'd2;
  localparam logic [1:0] REG_MEAS_NSE  = 2'd3;

  // Gain is Q1.16, time step is Q0.16
  localparam int unsigned UNIT_BITS = 16;
  localparam logic [16:0] ONE_GAIN  = 17'h10000;
  localparam logic [15:0] HALF_UNIT = 16'h8000;

  // Serial multiplier and divider both retire one bit of a 17-bit operand per cycle
  localparam int unsigned SER_STEPS = 17;
  localparam logic [4:0]  SER_LAST  = 5'(SER_STEPS - 1);

  // Sequencer states, one-hot
  typedef enum logic [10:0] {
    S_IDLE = 11'b000_0000_0001,
    S_PMUL = 11'b000_0000_0010,
    S_PRND = 11'b000_0000_0100,
    S_PAPP = 11'b000_0000_1000,
    S_USET = 11'b000_0001_0000,
    S_DINI = 11'b000_0010_0000,
    S_DIV  = 11'b000_0100_0000,
    S_UMUL = 11'b000_1000_0000,
    S_URND = 11'b001_0000_0000,
    S_UAPP = 11'b010_0000_0000,
    S_FIN  = 11'b100_0000_0000
  } state_t;

  // Clamp a 35-bit two's complement value to 32 signed bits
  function automatic logic [31:0] sat_s35(input logic [34:0] v);
    logic [31:0] r;
    if (v[34] == 1'b0 && v[33:31] != 3'b000) begin
      r = 32'h7FFF_FFFF;
    end else if (v[34] == 1'b1 && v[33:31] != 3'b111) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/scalar_kalman_filter.sv @@
// scalar_kalman_filter: 1-D Kalman filter, Q16.16 state, bit-serial datapath.
// Depends on skf_pkg (op codes, state encoding, saturation helper).
`default_nettype none

//  channel  | handshake             | payload
//  ---------+-----------------------+-----------------------------------------
//  cmd      | cmd_valid / cmd_ready | op, velocity, time_step, measurement
//  res      | res_valid / res_ready | position, variance, kalman_gain, residual
//  apb      | psel/penable/pwrite   | paddr, pwdata, prdata (pready tied high)
//
//  The shift-add multipliers and the restoring divider each retire one bit
//  of a 17-bit operand per cycle.
//  Synchronous active-high reset; estimate/variance/gain/residual return to
//  0 / 1.0 / 0 / 0 and the registers to their defaults.
//  A new command is taken while the previous result still waits in the
//  output register; the sequencer stalls in its last state only if that
//  register is full and not being drained when the next result is ready.

module scalar_kalman_filter #(
  parameter int FRACTION_BITS = 16
) (
  input  wire  logic               clk,
  input  wire  logic               rst,
  // command channel
  input  wire  logic               cmd_valid,
  output       logic               cmd_ready,
  input  wire  logic [1:0]         op,
  input  wire  logic signed [31:0] velocity,
  input  wire  logic [15:0]        time_step,
  input  wire  logic signed [31:0] measurement,
  // result channel
  output       logic               res_valid,
  input  wire  logic               res_ready,
  output       logic signed [31:0] position,
  output       logic [31:0]        variance,
  output       logic [16:0]        kalman_gain,
  output       logic signed [31:0] residual,
  // configuration port
  input  wire  logic               psel,
  input  wire  logic               penable,
  input  wire  logic               pwrite,
  input  wire  logic [3:0]         paddr,
  input  wire  logic [31:0]        pwdata,
  output       logic [31:0]        prdata,
  output       logic               pready
);
  import skf_pkg::*;

  // 1.0 in the state's Q format
  localparam logic [31:0] ONE_FIXED = 32'(1) << FRACTION_BITS;

  // configuration registers
  logic [31:0] init_pos;
  logic [31:0] init_var;
  logic [31:0] proc_nse;
  logic [31:0] meas_nse;

  // filter state
  logic [31:0] pos;
  logic [31:0] var_p;
  logic [16:0] gain;
  logic [31:0] resid;

  // sequencer and datapath
  state_t      state;
  op_t         op_q;
  logic [31:0] meas;
  logic [32:0] cand;      // multiplicand of lane A: velocity, later innovation y
  logic [16:0] mul_a;     // multiplier shift registers, MSB first
  logic [16:0] mul_b;
  logic [49:0] acc_a;     // signed product lane
  logic [48:0] acc_b;     // unsigned product lane
  logic [4:0]  cnt;
  logic [32:0] sum_s;     // innovation variance p + r
  logic [32:0] rem;       // divider remainder
  logic [16:0] quo;       // low dividend bits shift out, quotient bits shift in

  // combinational helpers
  logic [31:0] mcand_b;
  logic [49:0] rnd_a;
  logic [48:0] rnd_b;
  logic [33:0] div_t;
  logic        div_ge;
  logic [16:0] k_next;
  logic [48:0] num;
  logic [34:0] pos_sum;
  logic [33:0] var_sum;
  logic        cfg_wr;
  logic        res_load;  // output register takes the finished word

  assign cfg_wr    = psel && penable && pwrite && pready;
  assign pready    = 1'b1;
  assign cmd_ready = (state == S_IDLE);
  assign res_load  = (state == S_FIN) && (!res_valid || res_ready);

  always_comb begin
    case (paddr[3:2])
      REG_INIT_POS: prdata = init_pos;
      REG_INIT_VAR: prdata = init_var;
      REG_PROC_NSE: prdata = proc_nse;
      REG_MEAS_NSE: prdata = meas_nse;
      default:      prdata = '0;
    endcase
  end

  // lane B multiplies q during predict, the variance during update
  assign mcand_b = (state == S_UMUL) ? var_p : proc_nse;

  // round to nearest, ties up: floor((v + 2^15) / 2^16)
  assign rnd_a = acc_a + 50'(HALF_UNIT);
  assign rnd_b = acc_b + 49'(HALF_UNIT);

  // dividend p*2^16 + floor(s/2); quotient fits 17 bits since p <= s
  assign num = {1'b0, var_p, 16'h0000} + 49'(sum_s[32:1]);

  // one restoring step; zero s forces a zero gain
  assign div_t  = {rem, quo[16]};
  assign div_ge = (sum_s != 33'd0) && (div_t >= {1'b0, sum_s});
  assign k_next = {quo[15:0], div_ge};

  // estimate plus rounded correction, saturated later
  assign pos_sum = {{3{pos[31]}}, pos} + {acc_a[33], acc_a[33:0]};
  assign var_sum = {2'b00, var_p} + {1'b0, acc_b[32:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      res_valid <= 1'b0;
      init_pos <= '0;
      init_var <= ONE_FIXED;
      proc_nse <= '0;
      meas_nse <= ONE_FIXED;
      pos      <= '0;
      var_p    <= ONE_FIXED;
      gain     <= '0;
      resid    <= '0;
    end else begin
      if (cfg_wr) begin
        case (paddr[3:2])
          REG_INIT_POS: init_pos <= pwdata;
          REG_INIT_VAR: init_var <= pwdata;
          REG_PROC_NSE: proc_nse <= pwdata;
          REG_MEAS_NSE: meas_nse <= pwdata;
          default: ;
        endcase
      end

      // drained with nothing new behind it
      if (res_valid && res_ready && !res_load) begin
        res_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            op_q  <= op_t'(op);
            meas  <= measurement;
            cand  <= {velocity[31], velocity};
            mul_a <= {1'b0, time_step};
            mul_b <= {1'b0, time_step};
            acc_a <= '0;
            acc_b <= '0;
            cnt   <= '0;
            case (op_t'(op))
              OP_RESTART: begin
                pos   <= init_pos;
                var_p <= init_var;
                gain  <= '0;
                resid <= '0;
                state <= S_FIN;
              end
              OP_UPDATE: state <= S_USET;
              default:   state <= S_PMUL;
            endcase
          end
        end

        // lane A: u*dt, lane B: q*dt in predict; lane A: K*y, lane B: (1-K)*p in update
        S_PMUL, S_UMUL: begin
          acc_a <= {acc_a[48:0], 1'b0} + (mul_a[16] ? {{17{cand[32]}}, cand} : 50'd0);
          acc_b <= {acc_b[47:0], 1'b0} + (mul_b[16] ? {17'd0, mcand_b} : 49'd0);
          mul_a <= {mul_a[15:0], 1'b0};
          mul_b <= {mul_b[15:0], 1'b0};
          cnt   <= cnt + 5'd1;
          if (cnt == SER_LAST) begin
            state <= (state == S_PMUL) ? S_PRND : S_URND;
          end
        end

        S_PRND, S_URND: begin
          acc_a <= {{16{rnd_a[49]}}, rnd_a[49:16]};
          acc_b <= {16'd0, rnd_b[48:16]};
          state <= (state == S_PRND) ? S_PAPP : S_UAPP;
        end

        S_PAPP: begin
          pos   <= sat_s35(pos_sum);
          var_p <= (var_sum[33:32] != 2'b00) ? 32'hFFFF_FFFF : var_sum[31:0];
          state <= (op_q == OP_PRED_UPD) ? S_USET : S_FIN;
        end

        // innovation and innovation variance
        S_USET: begin
          cand  <= {meas[31], meas} - {pos[31], pos};
          sum_s <= {1'b0, var_p} + {1'b0, meas_nse};
          state <= S_DINI;
        end

        S_DINI: begin
          rem   <= {1'b0, num[48:17]};
          quo   <= num[16:0];
          cnt   <= '0;
          state <= S_DIV;
        end

        S_DIV: begin
          rem <= div_ge ? 33'(div_t - {1'b0, sum_s}) : div_t[32:0];
          quo <= k_next;
          cnt <= cnt + 5'd1;
          if (cnt == SER_LAST) begin
            // lane A: K*y, lane B: (1-K)*p
            mul_a <= k_next;
            mul_b <= ONE_GAIN - k_next;
            acc_a <= '0;
            acc_b <= '0;
            cnt   <= '0;
            state <= S_UMUL;
          end
        end

        S_UAPP: begin
          pos   <= sat_s35(pos_sum);
          var_p <= acc_b[31:0];
          gain  <= quo;
          resid <= sat_s35({{2{cand[32]}}, cand});
          state <= S_FIN;
        end

        S_FIN: begin
          if (res_load) begin
            position    <= pos;
            variance    <= var_p;
            kalman_gain <= gain;
            residual    <= resid;
            res_valid   <= 1'b1;
            state       <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // the update step can only shrink the variance
  a_var_shrinks: assert property (@(posedge clk) disable iff (rst)
    (state == S_UAPP) |-> (acc_b[31:0] <= var_p))
    else $error("update raised the variance");

  // gain from the divider never exceeds 1.0
  a_gain_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_UMUL) |-> (quo <= ONE_GAIN))
    else $error("gain above one");

  // an accepted command keeps the sequencer busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd_ready) |=> !cmd_ready)
    else $error("command taken while busy");

  // a result is loaded only into a free or draining output register
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && res_valid && !res_ready) |=> (state == S_FIN))
    else $error("result register overwritten");

endmodule

`default_nettype wire
